// ----- rtl/hlsp_pkg.sv -----
// package for the height-limited shortest path core
// sizes, commands, state and edge record types; no dependencies
package hlsp_pkg;
  localparam int unsigned MaxCities = 1024;
  localparam int unsigned MaxEdges  = 8192;
  localparam int unsigned CityW     = $clog2(MaxCities);
  localparam int unsigned EdgeW     = $clog2(MaxEdges);
  localparam int unsigned LinkW     = EdgeW + 1;
  localparam int unsigned CountW    = 11;
  localparam logic [31:0] InfValue  = 32'h3fff_ffff;

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdAdd   = 2'd1,
    CmdQuery = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CityW:0]  to;
    logic [15:0]     len;
    logic [29:0]     height;
    logic [LinkW-1:0] link;
  } edge_t;

  localparam int unsigned EdgeBits = $bits(edge_t);

  typedef enum logic [4:0] {
    StIdle, StAdd2, StHeadClr, StBsLoop, StInit, StPop, StPopW,
    StHeadRd, StHeadW, StEdgeRd, StEdgeW, StDistRd, StDistW, StRelax,
    StProbeDone, StDestRd, StDestW, StFinish, StOut
  } state_e;
endpackage

// ----- rtl/hlsp_ram.sv -----
// generic single-port-write ram with registered read
// no dependencies
module hlsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/height_limited_shortest_path_core.sv -----
// height-limited shortest path core: graph store, spfa probes, binary search
// depends on hlsp_pkg and hlsp_ram
// add road: an edge record each way, written in StAdd2 and then StHeadW; clear: full head table sweep
// query: one spfa probe per binary search step; each probe resets n distance and flag
// entries, then pops the queue and walks each city's edges, skipping closed ones, relaxing the rest;
// result through StFinish and StOut after the last probe, straight to StOut for a bad or equal endpoint
// reset: async low; head table swept to empty, tready low meanwhile
// one request at a time, tready low while an item is in work
module height_limited_shortest_path_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hlsp_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // end_a, end_b, road_length, road_height, road_unlimited,
  // start_city, dest_city, height_cap (lowest first), zero fill to 96
  input  logic [95:0]                   s_axis_tdata,
  // command
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // reachable, best_height, route_length (lowest first), zero fill to 56
  output logic [55:0]                   m_axis_tdata
);
  import hlsp_pkg::*;

  logic [1:0]  f_cmd;
  logic [10:0] f_a, f_b, f_s, f_d;
  logic [15:0] f_len, f_h, f_cap;
  logic        f_unl;
  assign f_cmd = s_axis_tuser;
  assign f_a   = s_axis_tdata[10:0];
  assign f_b   = s_axis_tdata[21:11];
  assign f_len = s_axis_tdata[37:22];
  assign f_h   = s_axis_tdata[53:38];
  assign f_unl = s_axis_tdata[54];
  assign f_s   = s_axis_tdata[65:55];
  assign f_d   = s_axis_tdata[76:66];
  assign f_cap = s_axis_tdata[92:77];

  state_e state_q, state_d;
  logic [CountW-1:0] ccount_q;
  logic [CountW-1:0] n_w;
  assign n_w = (ccount_q > CountW'(MaxCities)) ? CountW'(MaxCities) : ccount_q;

  // latched request
  logic [CityW-1:0] ra_q, ra_d, rb_q, rb_d, rd_q, rd_d;
  logic [15:0]      rlen_q, rlen_d;
  logic [29:0]      rh_q, rh_d;
  logic [16:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [31:0]      best_q, best_d, dx_q, dx_d, nd_q, nd_d;
  logic [LinkW-1:0] etot_q, etot_d, link_q, link_d;
  logic [CityW-1:0] x_q, x_d, sc_q, sc_d;
  logic [CityW:0]   cnt_q, cnt_d;
  logic [CityW-1:0] qh_q, qh_d;
  logic [CityW:0]   qc_q, qc_d;
  edge_t            ed_q, ed_d;
  logic [55:0]      out_q, out_d;
  logic             ovalid_q, ovalid_d;
  logic             qf_we, qf_val, qf_rd;
  logic [CityW-1:0] qf_idx;

  // head ram
  logic h_we; logic [CityW-1:0] h_wa, h_ra; logic [LinkW-1:0] h_wd, h_rd;
  hlsp_ram #(.Width(LinkW), .Depth(MaxCities)) u_head (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(h_ra),
    .rdata_o(h_rd));
  // edge ram
  logic e_we; logic [EdgeW-1:0] e_wa, e_ra; edge_t e_wd; logic [EdgeBits-1:0] e_rd;
  hlsp_ram #(.Width(EdgeBits), .Depth(MaxEdges)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra),
    .rdata_o(e_rd));
  // distance ram
  logic d_we; logic [CityW-1:0] d_wa, d_ra; logic [31:0] d_wd, d_rd;
  hlsp_ram #(.Width(32), .Depth(MaxCities)) u_dist (
    .clk_i, .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd), .raddr_i(d_ra),
    .rdata_o(d_rd));
  // work queue ram
  logic q_we; logic [CityW-1:0] q_wa, q_ra, q_rd, q_wd;
  hlsp_ram #(.Width(CityW), .Depth(MaxCities)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(q_ra),
    .rdata_o(q_rd));
  // queued flag ram, read at the edge target
  hlsp_ram #(.Width(1), .Depth(MaxCities)) u_qflag (
    .clk_i, .we_i(qf_we), .waddr_i(qf_idx), .wdata_i(qf_val),
    .raddr_i(ed_q.to[CityW-1:0]), .rdata_o(qf_rd));

  logic [LinkW-1:0] head_rd;
  assign head_rd = h_rd;
  logic [16:0] sum_lh;
  logic [32:0] ndsum;
  assign sum_lh = lo_q + hi_q;
  assign ndsum  = {1'b0, dx_q} + 33'(ed_q.len);

  always_comb begin
    state_d = state_q;
    ra_d = ra_q; rb_d = rb_q; rd_d = rd_q; rlen_d = rlen_q; rh_d = rh_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; best_d = best_q; dx_d = dx_q;
    nd_d = nd_q; etot_d = etot_q; link_d = link_q; x_d = x_q; sc_d = sc_q;
    cnt_d = cnt_q; qh_d = qh_q; qc_d = qc_q; ed_d = ed_q; out_d = out_q;
    ovalid_d = ovalid_q;
    h_we = 1'b0; h_wa = ra_q; h_wd = etot_q; h_ra = ra_q;
    e_we = 1'b0; e_wa = etot_q[EdgeW-1:0]; e_ra = EdgeW'(link_q - 1'b1);
    e_wd = '{to: {1'b0, rb_q}, len: rlen_q, height: rh_q, link: head_rd};
    d_we = 1'b0; d_wa = x_q; d_wd = nd_q; d_ra = ed_q.to[CityW-1:0];
    q_we = 1'b0; q_wa = CityW'(qh_q + qc_q[CityW-1:0]); q_ra = qh_q;
    q_wd = ed_q.to[CityW-1:0];
    qf_we = 1'b0; qf_idx = x_q; qf_val = 1'b0;
    s_axis_tready = 1'b0;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (state_q)
      StIdle: begin
        s_axis_tready = !ovalid_q;
        h_ra = CityW'(f_a - 11'd1);
        if (s_axis_tvalid && !ovalid_q) begin
          ra_d = CityW'(f_a - 11'd1); rb_d = CityW'(f_b - 11'd1);
          rlen_d = f_len; rh_d = f_unl ? InfValue[29:0] : {14'd0, f_h};
          sc_d = CityW'(f_s - 11'd1); rd_d = CityW'(f_d - 11'd1);
          case (cmd_e'(f_cmd))
            CmdClear: begin
              etot_d = '0; cnt_d = '0;
              state_d = StHeadClr;
            end
            CmdAdd: begin
              if (f_a != 0 && f_a <= n_w && f_b != 0 && f_b <= n_w &&
                  32'(etot_q) + 32'd2 <= 32'(MaxEdges))
                state_d = StAdd2;
            end
            CmdQuery: begin
              out_d = '0;
              if (f_s == 0 || f_s > n_w || f_d == 0 || f_d > n_w) begin
                state_d = StOut;
              end else if (f_s == f_d) begin
                out_d = 56'({32'd0, f_cap, 1'b1});
                state_d = StOut;
              end else begin
                lo_d = '0; hi_d = {1'b0, f_cap}; best_d = InfValue;
                state_d = StBsLoop;
              end
            end
            default: ;
          endcase
        end
      end
      StHeadClr: begin
        // sweep every head entry back to none
        h_we = 1'b1; h_wa = cnt_q[CityW-1:0]; h_wd = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (CityW+1)'(MaxCities - 1)) state_d = StIdle;
      end
      StAdd2: begin
        // first edge a->b, head read issued in idle
        e_we = 1'b1; h_we = 1'b1; h_wd = etot_q + 1'b1;
        etot_d = etot_q + 1'b1;
        ra_d = rb_q; rb_d = ra_q; h_ra = rb_q;
        state_d = StHeadW;
        cnt_d = '0;
      end
      StHeadW: begin
        // reverse edge b->a; a self loop links to the edge just written
        e_wd = '{to: {1'b0, rb_q}, len: rlen_q, height: rh_q,
                 link: (ra_q == rb_q) ? etot_q : head_rd};
        e_we = 1'b1; h_we = 1'b1; h_wd = etot_q + 1'b1;
        etot_d = etot_q + 1'b1;
        state_d = StIdle;
      end
      StBsLoop: begin
        if (lo_q[16] || lo_q > hi_q || hi_q[16]) begin
          state_d = StFinish;
        end else begin
          mid_d = sum_lh >> 1;
          cnt_d = '0;
          state_d = StInit;
        end
      end
      StInit: begin
        d_we = 1'b1; d_wa = cnt_q[CityW-1:0]; d_wd = InfValue;
        qf_we = 1'b1; qf_idx = cnt_q[CityW-1:0]; qf_val = 1'b0;
        if (cnt_q[CityW-1:0] == sc_q) begin
          d_wd = '0; qf_val = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 >= (CityW+1)'(n_w)) begin
          qh_d = '0; qc_d = (CityW+1)'(1); x_d = sc_q;
          q_we = 1'b1; q_wa = '0; q_wd = sc_q;
          state_d = StPop;
        end
      end
      StPop: begin
        if (qc_q == 0) begin
          d_ra = rd_q; state_d = StDestW;
        end else state_d = StPopW;
      end
      StPopW: begin
        x_d = q_rd; qh_d = qh_q + 1'b1; qc_d = qc_q - 1'b1;
        qf_we = 1'b1; qf_idx = q_rd; qf_val = 1'b0;
        h_ra = q_rd; d_ra = q_rd;
        state_d = StHeadRd;
      end
      StHeadRd: begin
        dx_d = d_rd; link_d = head_rd; state_d = StEdgeRd;
      end
      StEdgeRd: begin
        if (link_q == 0 || link_q > etot_q) state_d = StPop;
        else state_d = StEdgeW;
      end
      StEdgeW: begin
        ed_d = edge_t'(e_rd); state_d = StDistRd;
      end
      StDistRd: begin
        link_d = ed_q.link;
        nd_d = ndsum > 33'(InfValue) ? InfValue : ndsum[31:0];
        if (ed_q.height < 30'(mid_q) || (CountW)'(ed_q.to) + 11'd1 > n_w)
          state_d = StEdgeRd;
        else state_d = StDistW;
      end
      StDistW: state_d = StRelax;
      StRelax: begin
        if (nd_q < d_rd) begin
          d_we = 1'b1; d_wa = ed_q.to[CityW-1:0];
          if (!qf_rd && qc_q < (CityW+1)'(MaxCities)) begin
            q_we = 1'b1;
            qc_d = qc_q + 1'b1;
            qf_we = 1'b1; qf_idx = ed_q.to[CityW-1:0]; qf_val = 1'b1;
          end
        end
        state_d = StEdgeRd;
      end
      StDestW: begin
        d_ra = rd_q; state_d = StProbeDone;
      end
      StProbeDone: begin
        if (d_rd != InfValue) begin
          lo_d = mid_q + 1'b1; best_d = d_rd;
        end else if (mid_q == 0) begin
          hi_d = 17'h1ffff;
        end else hi_d = mid_q - 1'b1;
        state_d = StBsLoop;
      end
      StFinish: begin
        if (best_q != InfValue) out_d = 56'({best_q, hi_q[15:0], 1'b1});
        state_d = StOut;
      end
      StOut: begin
        ovalid_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHeadClr; ccount_q <= CountW'(1024); etot_q <= '0;
      ovalid_q <= 1'b0; cnt_q <= '0;
    end else begin
      state_q <= state_d; etot_q <= etot_d; ovalid_q <= ovalid_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) ccount_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= ra_d; rb_q <= rb_d; rd_q <= rd_d; rlen_q <= rlen_d; rh_q <= rh_d;
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d; best_q <= best_d; dx_q <= dx_d;
    nd_q <= nd_d; link_q <= link_d; x_q <= x_d; sc_q <= sc_d;
    qh_q <= qh_d; qc_q <= qc_d; ed_q <= ed_d; out_q <= out_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !s_axis_tready)
    else $error("ready while busy");
  a_etot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(etot_q) <= 32'(MaxEdges))
    else $error("edge count overflow");
endmodule

// ----- dv/height_limited_shortest_path_core_test.sv -----
// testbench for height_limited_shortest_path_core: road adds, clears and height queries
// on a stream port, checked against a built-in predictor; needs rtl/hlsp_pkg.sv and the core
`timescale 1ns / 100ps

typedef struct {
  bit        reachable;
  bit [15:0] best_height;
  bit [31:0] route_length;
} route_answer_t;

class route_scoreboard;
  int unsigned   city_limit = 1024;
  int unsigned   edge_to [hlsp_pkg::MaxEdges];
  int unsigned   edge_len [hlsp_pkg::MaxEdges];
  int unsigned   edge_height [hlsp_pkg::MaxEdges];
  int unsigned   edge_next [hlsp_pkg::MaxEdges];
  int unsigned   first_edge [hlsp_pkg::MaxCities + 1];
  int unsigned   edges_used;
  int unsigned   probe_dist [hlsp_pkg::MaxCities + 1];
  bit            in_queue [hlsp_pkg::MaxCities + 1];
  int unsigned   visit_queue [hlsp_pkg::MaxCities];
  route_answer_t pending_answers [$];
  int            errors;

  function int unsigned live_cities();
    return (city_limit > hlsp_pkg::MaxCities) ? hlsp_pkg::MaxCities : city_limit;
  endfunction

  function void link_edge(int unsigned from, int unsigned to, int unsigned len,
                          int unsigned height);
    edge_to[edges_used] = to;
    edge_len[edges_used] = len;
    edge_height[edges_used] = height;
    edge_next[edges_used] = first_edge[from];
    edges_used++;
    first_edge[from] = edges_used;
  endfunction

  // queue-based relaxation, edges lower than min_height are closed
  function int unsigned shortest_at(int unsigned src, int unsigned dst,
                                    int unsigned min_height, int unsigned n);
    int unsigned qh, qc, x, lk, nd, t;
    for (int i = 1; i <= n; i++) begin
      probe_dist[i] = hlsp_pkg::InfValue;
      in_queue[i] = 0;
    end
    qh = 0;
    qc = 1;
    probe_dist[src] = 0;
    visit_queue[0] = src;
    in_queue[src] = 1;
    while (qc != 0) begin
      x = visit_queue[qh];
      qh = (qh + 1) % hlsp_pkg::MaxCities;
      qc--;
      in_queue[x] = 0;
      lk = first_edge[x];
      while (lk != 0 && lk <= edges_used) begin
        t = edge_to[lk-1];
        if (!(edge_height[lk-1] < min_height || t == 0 || t > n)) begin
          nd = probe_dist[x] + edge_len[lk-1];
          if (nd > hlsp_pkg::InfValue) nd = hlsp_pkg::InfValue;
          if (nd < probe_dist[t]) begin
            probe_dist[t] = nd;
            if (!in_queue[t] && qc < hlsp_pkg::MaxCities) begin
              visit_queue[(qh + qc) % hlsp_pkg::MaxCities] = t;
              qc++;
              in_queue[t] = 1;
            end
          end
        end
        lk = edge_next[lk-1];
      end
    end
    return probe_dist[dst];
  endfunction

  function void note_request(bit [97:0] d);
    hlsp_pkg::cmd_e cmd;
    int unsigned    n, a, b, h, s, t, r, best;
    int             lo, hi, mid;
    route_answer_t  ans;
    cmd = hlsp_pkg::cmd_e'(d[1:0]);
    n = live_cities();
    case (cmd)
      hlsp_pkg::CmdClear: begin
        foreach (first_edge[i]) first_edge[i] = 0;
        edges_used = 0;
      end
      hlsp_pkg::CmdAdd: begin
        a = d[12:2];
        b = d[23:13];
        h = d[56] ? hlsp_pkg::InfValue : d[55:40];
        if (a != 0 && a <= n && b != 0 && b <= n && edges_used + 2 <= hlsp_pkg::MaxEdges) begin
          link_edge(a, b, d[39:24], h);
          link_edge(b, a, d[39:24], h);
        end
      end
      hlsp_pkg::CmdQuery: begin
        s = d[67:57];
        t = d[78:68];
        ans = '{0, 0, 0};
        if (s != 0 && s <= n && t != 0 && t <= n) begin
          lo = 0;
          hi = d[94:79];
          best = hlsp_pkg::InfValue;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            r = shortest_at(s, t, mid, n);
            if (r != hlsp_pkg::InfValue) begin
              lo = mid + 1;
              best = r;
            end else begin
              hi = mid - 1;
            end
          end
          if (best != hlsp_pkg::InfValue) ans = '{1, hi[15:0], best};
        end
        pending_answers.push_back(ans);
      end
      default: ;
    endcase
  endfunction

  function void check_result(bit [55:0] d);
    route_answer_t want;
    if (pending_answers.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, d);
      errors++;
      return;
    end
    want = pending_answers.pop_front();
    if (d[0] !== want.reachable) begin
      $display("%0t: reachable mismatch, expected %0d, actual %0d", $time, want.reachable, d[0]);
      errors++;
    end
    if (d[16:1] !== want.best_height) begin
      $display("%0t: best_height mismatch, expected %0d, actual %0d", $time,
               want.best_height, d[16:1]);
      errors++;
    end
    if (d[48:17] !== want.route_length) begin
      $display("%0t: route_length mismatch, expected %0d, actual %0d", $time,
               want.route_length, d[48:17]);
      errors++;
    end
  endfunction
endclass

module height_limited_shortest_path_core_test;
  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [10:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [55:0]  m_axis_tdata;

  route_scoreboard routes;
  int unsigned     burst_left;
  int unsigned     max_gap;
  int unsigned     ready_mode;
  int unsigned     hold_request;

  height_limited_shortest_path_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #400_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: optional long hold, then stall pattern by mode
  initial begin
    int unsigned hold_left, stall_left;
    hold_left = 0;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else if (ready_mode == 0) begin
        m_axis_tready = 1'b1;
      end else if (ready_mode == 1) begin
        m_axis_tready = $urandom_range(0, 1);
      end else if (stall_left != 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) routes.check_result(m_axis_tdata);
  end

  // command in the two lowest bits, the tdata fields above it
  function automatic bit [97:0] pack_request(hlsp_pkg::cmd_e cmd, bit [10:0] a, bit [10:0] b,
                                             bit [15:0] len, bit [15:0] h, bit unl,
                                             bit [10:0] s, bit [10:0] d, bit [15:0] cap);
    return {3'd0, cap, d, s, unl, h, len, b, a, cmd};
  endfunction

  task automatic send_request(bit [97:0] d);
    if (burst_left == 0) begin
      if (max_gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(0, max_gap)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = d[1:0];
    s_axis_tdata = d[97:2];
    do @(posedge clk_i); while (!s_axis_tready);
    routes.note_request(d);
  endtask

  // stop offering and wait for all answers plus a clear sweep
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (routes.pending_answers.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic write_city_count(bit [10:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    routes.city_limit = v;
  endtask

  function automatic bit [10:0] pick_city(int unsigned n);
    if (n == 0 || $urandom_range(0, 15) == 0) return $urandom_range(0, 2047);
    return $urandom_range(1, n);
  endfunction

  task automatic random_phase(bit [10:0] count, int unsigned items, int unsigned cap_max);
    int unsigned    n, k;
    bit [15:0]      h, cap;
    hlsp_pkg::cmd_e cmd;
    write_city_count(count);
    n = routes.live_cities();
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 99);
      cmd = (k < 3) ? hlsp_pkg::CmdClear : (k < 60) ? hlsp_pkg::CmdAdd :
            (k < 96) ? hlsp_pkg::CmdQuery : hlsp_pkg::CmdNone;
      h = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
      cap = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, cap_max));
      send_request(pack_request(cmd, pick_city(n), pick_city(n),
                                ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                16'($urandom_range(0, 50)),
                                h, $urandom_range(0, 9) == 0, pick_city(n), pick_city(n), cap));
    end
    drain();
  endtask

  initial begin
    routes = new();
    burst_left = 0;
    max_gap = 0;
    ready_mode = 0;
    hold_request = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty graph, limited and unlimited roads, bad ends, extremes
    send_request(pack_request(hlsp_pkg::CmdQuery, 0, 0, 0, 0, 0, 1, 2, 16'hffff));
    send_request(pack_request(hlsp_pkg::CmdAdd, 1, 2, 5, 10, 0, 0, 0, 0));
    send_request(pack_request(hlsp_pkg::CmdAdd, 2, 3, 7, 0, 1, 0, 0, 0));
    send_request(pack_request(hlsp_pkg::CmdAdd, 1, 3, 100, 3, 0, 0, 0, 0));
    send_request(pack_request(hlsp_pkg::CmdAdd, 3, 3, 1, 9, 0, 0, 0, 0));
    send_request(pack_request(hlsp_pkg::CmdQuery, 0, 0, 0, 0, 0, 1, 3, 16'hffff));
    send_request(pack_request(hlsp_pkg::CmdQuery, 0, 0, 0, 0, 0, 1, 3, 0));
    send_request(pack_request(hlsp_pkg::CmdQuery, 0, 0, 0, 0, 0, 2, 3, 16'hffff));
    send_request(pack_request(hlsp_pkg::CmdQuery, 0, 0, 0, 0, 0, 7, 7, 77));
    send_request(pack_request(hlsp_pkg::CmdQuery, 0, 0, 0, 0, 0, 0, 3, 9));
    send_request(pack_request(hlsp_pkg::CmdQuery, 0, 0, 0, 0, 0, 1, 1025, 9));
    send_request(pack_request(hlsp_pkg::CmdAdd, 0, 5, 1, 1, 0, 0, 0, 0));
    send_request(pack_request(hlsp_pkg::CmdAdd, 1, 2000, 1, 1, 0, 0, 0, 0));
    send_request(pack_request(hlsp_pkg::CmdAdd, 1024, 3, 16'hffff, 16'hffff, 0, 0, 0, 0));
    send_request(pack_request(hlsp_pkg::CmdNone, 11'h7ff, 11'h7ff, 16'hffff, 16'hffff, 1,
                              11'h7ff, 11'h7ff, 16'hffff));
    send_request(pack_request(hlsp_pkg::CmdQuery, 0, 0, 0, 0, 0, 1024, 2, 16'hffff));
    send_request(pack_request(hlsp_pkg::CmdQuery, 0, 0, 0, 0, 0, 1024, 1024, 16'hffff));
    send_request(pack_request(hlsp_pkg::CmdClear, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(pack_request(hlsp_pkg::CmdQuery, 0, 0, 0, 0, 0, 1, 3, 16'hffff));
    drain();

    // random phases; graph carries over so a shrunk count skips old edges
    max_gap = 4;
    ready_mode = 2;
    hold_request = 400;
    random_phase(32, 200, 31);
    ready_mode = 1;
    random_phase(8, 200, 31);
    max_gap = 0;
    ready_mode = 0;
    random_phase(16, 200, 15);
    max_gap = 6;
    ready_mode = 2;
    random_phase(1, 80, 15);
    random_phase(0, 60, 15);
    random_phase(2047, 80, 3);
    ready_mode = 1;
    random_phase(12, 250, 31);
    max_gap = 2;
    random_phase(1024, 60, 3);
    ready_mode = 2;
    random_phase(5, 250, 63);

    if (routes.pending_answers.size() != 0) routes.errors++;
    if (routes.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
